>>> rtl/goti_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the gas oven thermostat and igniter block.
package goti_pkg;

    // Field widths
    localparam int TS_W   = 32;   // millisecond timestamp
    localparam int MV_W   = 16;   // millivolt readings and limits
    localparam int TEMP_W = 14;   // temperature in 1/16 C, signed
    localparam int S10_W  = 20;   // ten times a millivolt reading
    localparam int P_W    = 29;   // scaled numerator (s10 - vref) * 620
    localparam int Q_W    = 13;   // quotient, below 8 * 620

    localparam logic signed [TEMP_W-1:0] TEMP_MIN_X16 = -14'sd160;
    localparam logic signed [TEMP_W-1:0] TEMP_MAX_X16 = 14'sd4800;
    localparam logic [9:0]               TEMP_SPAN_X16 = 10'd620;

    // Register indexes on the configuration port
    localparam logic [2:0] REG_TEMP_ON  = 3'd0;
    localparam logic [2:0] REG_TEMP_OFF = 3'd1;
    localparam logic [2:0] REG_IGNITE   = 3'd2;
    localparam logic [2:0] REG_VREF_MIN = 3'd3;
    localparam logic [2:0] REG_VREF_MAX = 3'd4;

    typedef enum logic [1:0] {
        MODE_IDLE     = 2'd0,
        MODE_IGNITING = 2'd1,
        MODE_HEATING  = 2'd2
    } heat_mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCALE,
        ST_MULT,
        ST_DIV,
        ST_FINISH
    } ctl_state_t;

endpackage

>>> rtl/goti_div.sv
`timescale 1ns / 1ps
// Bit-serial restoring divider: one quotient bit per cycle.
module goti_div (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [goti_pkg::P_W-1:0]   dividend,
    input  logic [goti_pkg::MV_W-1:0]  divisor,
    output logic                       done,
    output logic [goti_pkg::Q_W-1:0]   quotient
);

    localparam int CNT_W = $clog2(goti_pkg::P_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(goti_pkg::P_W - 1);

    logic                      busy_reg, busy_next;
    logic                      done_reg, done_next;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic [goti_pkg::MV_W-1:0] rem_reg, rem_next;
    logic [goti_pkg::MV_W-1:0] dvs_reg, dvs_next;
    logic [goti_pkg::P_W-1:0]  num_reg, num_next;
    logic [goti_pkg::Q_W-1:0]  quo_reg, quo_next;
    logic [goti_pkg::MV_W:0]   rem_sh;
    logic [goti_pkg::MV_W:0]   rem_sub;
    logic                      ge;

    always_comb begin
        rem_sh  = {rem_reg, num_reg[goti_pkg::P_W-1]};
        ge      = rem_sh >= {1'b0, dvs_reg};
        rem_sub = rem_sh - {1'b0, dvs_reg};

        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        num_next  = num_reg;
        quo_next  = quo_reg;

        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_LAST;
            rem_next  = '0;
            dvs_next  = divisor;
            num_next  = dividend;
            quo_next  = '0;
        end else if (busy_reg) begin
            // remainder stays below the divisor, so its low bits hold it
            rem_next = ge ? rem_sub[goti_pkg::MV_W-1:0] : rem_sh[goti_pkg::MV_W-1:0];
            num_next = {num_reg[goti_pkg::P_W-2:0], 1'b0};
            quo_next = {quo_reg[goti_pkg::Q_W-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        num_reg <= num_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

>>> rtl/gas_oven_thermostat_igniter_top.sv
`timescale 1ns / 1ps
// Top level of the gas oven hysteresis thermostat with timed igniter.
//
//  Channel     Direction  Request contents
//  s_axis      in         one control tick: timestamp, vref, signal, door flag
//  m_axis      out        one result: gas, igniter, heat state, faults, temperature
//  APB         in/out     five configuration registers at byte addresses 0..16
//
// A request passes through these steps from acceptance to a valid result:
// scale the readings and check limits, form the numerator, run the bit-serial
// divider until its done flag, then update the heater state. The next request
// is accepted once the result is loaded and the control is back in idle, so the
// block does not take a new request while one is being processed.
// Reset (aresetn low, synchronous) restores the register defaults, idles the
// heater and clears the igniter start time. A stalled result sits in the output
// register; the next request is accepted meanwhile and waits in its finishing
// step until the result slot frees.
module gas_oven_thermostat_igniter_top (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [31:0] now_ms, [47:32] vref_mv, [63:48] sense_mv, [64] door_ajar, rest zero
    input  logic [71:0] s_axis_tdata,

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [0] gas_on, [1] spark_on, [3:2] heat_state, [4] ref_fault,
    // [5] sense_fault, [19:6] temperature_x16, rest zero
    output logic [23:0] m_axis_tdata,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int TS_W   = goti_pkg::TS_W;
    localparam int MV_W   = goti_pkg::MV_W;
    localparam int TEMP_W = goti_pkg::TEMP_W;
    localparam int S10_W  = goti_pkg::S10_W;
    localparam int P_W    = goti_pkg::P_W;
    localparam int Q_W    = goti_pkg::Q_W;

    localparam logic signed [TEMP_W-1:0] TEMP_ON_RST  = 14'sd2848;
    localparam logic signed [TEMP_W-1:0] TEMP_OFF_RST = 14'sd2912;
    localparam logic [MV_W-1:0]          IGNITE_RST   = 16'd5000;
    localparam logic [MV_W-1:0]          VMIN_RST     = 16'd4500;
    localparam logic [MV_W-1:0]          VMAX_RST     = 16'd5500;

    // Configuration registers
    logic signed [TEMP_W-1:0] temp_on_reg, temp_off_reg;
    logic [MV_W-1:0]          ignite_reg, vmin_reg, vmax_reg;
    logic                     cfg_wr;
    logic [2:0]               cfg_idx;

    // Control state
    goti_pkg::ctl_state_t state_reg, state_next;
    goti_pkg::heat_mode_t mode_reg, mode_next;
    logic [TS_W-1:0]      ign_start_reg, ign_start_next;

    // Captured request and scaled values
    logic [TS_W-1:0]  now_reg, now_next;
    logic [MV_W-1:0]  vref_reg, vref_next;
    logic [MV_W-1:0]  sig_reg, sig_next;
    logic             door_reg, door_next;
    logic [S10_W-1:0] s10_reg, s10_next;
    logic             lo_reg, lo_next;
    logic             hi_reg, hi_next;
    logic             vfault_reg, vfault_next;
    logic             sfault_reg, sfault_next;

    // Output slot
    logic             m_valid_reg, m_valid_next;
    logic [23:0]      m_data_reg, m_data_next;

    // Datapath helpers
    logic [S10_W-1:0]        s10_comb, v9_comb, num_diff;
    logic [P_W:0]            prod_full;
    logic                    div_start, div_done;
    logic [Q_W-1:0]          div_q;
    logic signed [TEMP_W-1:0] temp;
    logic [TS_W-1:0]         elapsed;
    logic                    fault;
    logic [1:0]              heat_code;

    // ---------------- configuration port ----------------
    assign pready  = 1'b1;
    assign cfg_idx = paddr[4:2];
    assign cfg_wr  = psel & penable & pwrite & pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            temp_on_reg  <= TEMP_ON_RST;
            temp_off_reg <= TEMP_OFF_RST;
            ignite_reg   <= IGNITE_RST;
            vmin_reg     <= VMIN_RST;
            vmax_reg     <= VMAX_RST;
        end else if (cfg_wr) begin
            case (cfg_idx)
                goti_pkg::REG_TEMP_ON:  temp_on_reg  <= pwdata[TEMP_W-1:0];
                goti_pkg::REG_TEMP_OFF: temp_off_reg <= pwdata[TEMP_W-1:0];
                goti_pkg::REG_IGNITE:   ignite_reg   <= pwdata[MV_W-1:0];
                goti_pkg::REG_VREF_MIN: vmin_reg     <= pwdata[MV_W-1:0];
                goti_pkg::REG_VREF_MAX: vmax_reg     <= pwdata[MV_W-1:0];
                default: ;  // drop writes to unmapped addresses
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            goti_pkg::REG_TEMP_ON:  prdata = {18'd0, temp_on_reg};
            goti_pkg::REG_TEMP_OFF: prdata = {18'd0, temp_off_reg};
            goti_pkg::REG_IGNITE:   prdata = {16'd0, ignite_reg};
            goti_pkg::REG_VREF_MIN: prdata = {16'd0, vmin_reg};
            goti_pkg::REG_VREF_MAX: prdata = {16'd0, vmax_reg};
            default:                prdata = '0;
        endcase
    end

    // ---------------- divider ----------------
    // Numerator (10*signal - vref) * 620, valid only when neither clamp hits;
    // otherwise the quotient is ignored.
    assign num_diff  = s10_reg - {4'd0, vref_reg};
    assign prod_full = {10'd0, num_diff} * {20'd0, goti_pkg::TEMP_SPAN_X16};
    assign div_start = (state_reg == goti_pkg::ST_MULT);

    goti_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (prod_full[P_W-1:0]),
        .divisor  (vref_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    // ---------------- scaling, temperature, heater ----------------
    assign s10_comb = {4'd0, sig_reg} * 20'd10;
    assign v9_comb  = {4'd0, vref_reg} * 20'd9;

    // Clamp at both ends of the span; in between the quotient stays below 4960.
    assign temp = lo_reg ? goti_pkg::TEMP_MIN_X16 :
                  hi_reg ? goti_pkg::TEMP_MAX_X16 :
                  goti_pkg::TEMP_MIN_X16 + $signed({1'b0, div_q});

    // Wrapping timestamp difference since the gas opened
    assign elapsed = now_reg - ign_start_reg;
    assign fault   = door_reg | vfault_reg | sfault_reg;

    always_comb begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        ign_start_next = ign_start_reg;
        now_next       = now_reg;
        vref_next      = vref_reg;
        sig_next       = sig_reg;
        door_next      = door_reg;
        s10_next       = s10_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        vfault_next    = vfault_reg;
        sfault_next    = sfault_reg;
        m_data_next    = m_data_reg;
        heat_code      = goti_pkg::MODE_IDLE;
        s_axis_tready  = 1'b0;

        // Free the output slot once the consumer takes the result
        m_valid_next = m_valid_reg & ~m_axis_tready;

        case (state_reg)
            goti_pkg::ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    now_next   = s_axis_tdata[31:0];
                    vref_next  = s_axis_tdata[47:32];
                    sig_next   = s_axis_tdata[63:48];
                    door_next  = s_axis_tdata[64];
                    state_next = goti_pkg::ST_SCALE;
                end
            end
            goti_pkg::ST_SCALE: begin
                // Limit checks and clamp flags on the scaled readings
                s10_next    = s10_comb;
                lo_next     = s10_comb <= {4'd0, vref_reg};
                hi_next     = s10_comb >= v9_comb;
                vfault_next = (vref_reg < vmin_reg) || (vref_reg > vmax_reg);
                sfault_next = (s10_comb < {4'd0, vref_reg}) || (s10_comb > v9_comb);
                state_next  = goti_pkg::ST_MULT;
            end
            goti_pkg::ST_MULT: begin
                // Launch the divider with the product formed this cycle
                state_next = goti_pkg::ST_DIV;
            end
            goti_pkg::ST_DIV: begin
                if (div_done) begin
                    state_next = goti_pkg::ST_FINISH;
                end
            end
            goti_pkg::ST_FINISH: begin
                // Hold until the output slot is free, then advance the heater once
                if (!m_valid_reg || m_axis_tready) begin
                    if (fault) begin
                        mode_next = goti_pkg::MODE_IDLE;
                    end else begin
                        case (mode_reg)
                            goti_pkg::MODE_IDLE: begin
                                if (temp <= temp_on_reg) begin
                                    mode_next      = goti_pkg::MODE_IGNITING;
                                    ign_start_next = now_reg;
                                end
                            end
                            goti_pkg::MODE_IGNITING: begin
                                if (temp >= temp_off_reg) begin
                                    mode_next = goti_pkg::MODE_IDLE;
                                end else if (elapsed >= {16'd0, ignite_reg}) begin
                                    mode_next = goti_pkg::MODE_HEATING;
                                end
                            end
                            default: begin
                                if (temp >= temp_off_reg) begin
                                    mode_next = goti_pkg::MODE_IDLE;
                                end
                            end
                        endcase
                    end

                    case (mode_next)
                        goti_pkg::MODE_IDLE:     heat_code = goti_pkg::MODE_IDLE;
                        goti_pkg::MODE_IGNITING: heat_code = goti_pkg::MODE_IGNITING;
                        default:                 heat_code = goti_pkg::MODE_HEATING;
                    endcase

                    m_data_next = {4'd0, temp, sfault_reg, vfault_reg, heat_code,
                                   mode_next == goti_pkg::MODE_IGNITING,
                                   mode_next != goti_pkg::MODE_IDLE};
                    m_valid_next = 1'b1;
                    state_next   = goti_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = goti_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= goti_pkg::ST_IDLE;
            mode_reg      <= goti_pkg::MODE_IDLE;
            ign_start_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            ign_start_reg <= ign_start_next;
            m_valid_reg   <= m_valid_next;
        end
        now_reg    <= now_next;
        vref_reg   <= vref_next;
        sig_reg    <= sig_next;
        door_reg   <= door_next;
        s10_reg    <= s10_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        vfault_reg <= vfault_next;
        sfault_reg <= sfault_next;
        m_data_reg <= m_data_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

endmodule

>>> verif/gas_oven_thermostat_igniter_top_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the gas oven thermostat and igniter: control ticks in, checked results out.
module gas_oven_thermostat_igniter_top_tb;

    localparam int CYCLE_LIMIT = 600_000;
    // Spare index beyond the register map; writes to it must change nothing
    localparam logic [2:0] REG_SPARE = 3'd6;

    // One control tick as sent on the input channel
    typedef struct {
        logic [31:0] now_ms;
        logic [15:0] vref_mv;
        logic [15:0] sense_mv;
        logic        door_ajar;
    } oven_tick_t;

    // One result as expected on the output channel
    typedef struct {
        logic              gas_on;
        logic              spark_on;
        logic [1:0]        heat_state;
        logic              ref_fault;
        logic              sense_fault;
        logic signed [13:0] temperature_x16;
    } oven_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;

    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // [31:0] now_ms, [47:32] vref_mv, [63:48] sense_mv, [64] door_ajar, rest zero
    logic [71:0] s_axis_tdata = '0;

    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // [0] gas_on, [1] spark_on, [3:2] heat_state, [4] ref_fault,
    // [5] sense_fault, [19:6] temperature_x16, rest zero
    logic [23:0] m_axis_tdata;

    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    gas_oven_thermostat_igniter_top uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // 100 MHz clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Shadow copy of the configuration registers, reset values first
    logic signed [13:0] temp_on_cfg  = 14'sd2848;
    logic signed [13:0] temp_off_cfg = 14'sd2912;
    logic [15:0]        ignite_cfg   = 16'd5000;
    logic [15:0]        vref_min_cfg = 16'd4500;
    logic [15:0]        vref_max_cfg = 16'd5500;

    // Shadow heater state
    goti_pkg::heat_mode_t heater_mode = goti_pkg::MODE_IDLE;
    logic [31:0] ignite_start_ms = '0;

    oven_tick_t   pending_ticks[$];
    oven_result_t expected_results[$];
    oven_tick_t   sent_tick;

    bit          quiet_run = 1'b0;   // no idling on either side while set
    logic [31:0] oven_clock_ms = '0; // running timestamp for well-formed sequences
    int          cycle_count = 0;
    int          mismatches = 0;
    int          ticks_sent = 0;
    int          results_checked = 0;
    int          settings_applied = 0;
    int          heating_seen = 0;
    int          igniting_seen = 0;
    int          ref_faults_seen = 0;
    int          sense_faults_seen = 0;

    // Advance the shadow thermostat by one tick and return what the block must report.
    function automatic oven_result_t thermostat_step(oven_tick_t t);
        longint       v;
        longint       s10;
        longint       v9;
        longint       q;
        int           temp;
        logic         vf;
        logic         sf;
        logic [31:0]  elapsed;
        oven_result_t r;
        v   = longint'(t.vref_mv);
        s10 = longint'(t.sense_mv) * 10;
        v9  = v * 9;
        vf  = (t.vref_mv < vref_min_cfg) || (t.vref_mv > vref_max_cfg);
        sf  = (s10 < v) || (s10 > v9);
        // Clamp at both ends first, so a zero reference never reaches the divide
        if (s10 <= v) begin
            temp = int'(goti_pkg::TEMP_MIN_X16);
        end else if (s10 >= v9) begin
            temp = int'(goti_pkg::TEMP_MAX_X16);
        end else begin
            q = ((s10 - v) * longint'(goti_pkg::TEMP_SPAN_X16)) / v;
            temp = int'(goti_pkg::TEMP_MIN_X16) + int'(q);
        end
        elapsed = t.now_ms - ignite_start_ms;
        if (t.door_ajar || vf || sf) begin
            heater_mode = goti_pkg::MODE_IDLE;
        end else if (heater_mode != goti_pkg::MODE_IDLE) begin
            // Overheat wins over the igniter timer
            if (temp >= int'(temp_off_cfg)) begin
                heater_mode = goti_pkg::MODE_IDLE;
            end else if (heater_mode == goti_pkg::MODE_IGNITING &&
                         elapsed >= 32'(ignite_cfg)) begin
                heater_mode = goti_pkg::MODE_HEATING;
            end
        end else if (temp <= int'(temp_on_cfg)) begin
            // Timer is not looked at on the tick the gas opens
            heater_mode = goti_pkg::MODE_IGNITING;
            ignite_start_ms = t.now_ms;
        end
        r.gas_on          = (heater_mode != goti_pkg::MODE_IDLE);
        r.spark_on        = (heater_mode == goti_pkg::MODE_IGNITING);
        r.heat_state      = heater_mode;
        r.ref_fault       = vf;
        r.sense_fault     = sf;
        r.temperature_x16 = temp[13:0];
        return r;
    endfunction

    task automatic check_field(string name, logic [13:0] want, logic [13:0] got);
        if (got !== want) begin
            $display("%0t ns: %s mismatch, expected 0x%h, got 0x%h", $time, name, want, got);
            mismatches++;
        end
    endtask

    // Sender: predict on each accepted request, then offer the next one or idle.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                expected_results.push_back(thermostat_step(sent_tick));
                ticks_sent++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_ticks.size() != 0 && (quiet_run || $urandom_range(99) >= 25)) begin
                    sent_tick = pending_ticks.pop_front();
                    s_axis_tdata  <= {7'b0, sent_tick.door_ajar, sent_tick.sense_mv,
                                      sent_tick.vref_mv, sent_tick.now_ms};
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: check each accepted result against the oldest expectation, stall at random.
    always @(posedge aclk) begin
        oven_result_t want;
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t ns: unexpected result, expected none, got 0x%h",
                             $time, m_axis_tdata);
                    mismatches++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("gas_on", 14'(want.gas_on), 14'(m_axis_tdata[0]));
                    check_field("spark_on", 14'(want.spark_on), 14'(m_axis_tdata[1]));
                    check_field("heat_state", 14'(want.heat_state), 14'(m_axis_tdata[3:2]));
                    check_field("ref_fault", 14'(want.ref_fault), 14'(m_axis_tdata[4]));
                    check_field("sense_fault", 14'(want.sense_fault), 14'(m_axis_tdata[5]));
                    check_field("temperature_x16", want.temperature_x16, m_axis_tdata[19:6]);
                    check_field("padding", 14'd0, 14'(m_axis_tdata[23:20]));
                    results_checked++;
                    if (want.heat_state == goti_pkg::MODE_HEATING) heating_seen++;
                    if (want.heat_state == goti_pkg::MODE_IGNITING) igniting_seen++;
                    if (want.ref_fault) ref_faults_seen++;
                    if (want.sense_fault) sense_faults_seen++;
                end
            end
            m_axis_tready <= quiet_run || ($urandom_range(99) >= 25);
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL gas_oven_thermostat_igniter_top");
            $finish;
        end
    end

    task automatic queue_tick(logic [31:0] now, logic [15:0] vref, logic [15:0] sig,
                              logic door);
        oven_tick_t t;
        t.now_ms    = now;
        t.vref_mv   = vref;
        t.sense_mv  = sig;
        t.door_ajar = door;
        pending_ticks.push_back(t);
    endtask

    // Hold until the block has nothing in flight; sample away from the active edge.
    task automatic wait_drained();
        @(negedge aclk);
        while (pending_ticks.size() != 0 || s_axis_tvalid || expected_results.size() != 0)
            @(negedge aclk);
    endtask

    // Setup cycle, then access cycle; the register takes the value at the access edge.
    task automatic write_reg(logic [2:0] idx, logic [31:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            goti_pkg::REG_TEMP_ON:  temp_on_cfg  = value[13:0];
            goti_pkg::REG_TEMP_OFF: temp_off_cfg = value[13:0];
            goti_pkg::REG_IGNITE:   ignite_cfg   = value[15:0];
            goti_pkg::REG_VREF_MIN: vref_min_cfg = value[15:0];
            goti_pkg::REG_VREF_MAX: vref_max_cfg = value[15:0];
            default: ;
        endcase
    endtask

    task automatic apply_setting(int on_x16, int off_x16, int ign, int vmin, int vmax);
        write_reg(goti_pkg::REG_TEMP_ON, 32'(on_x16));
        write_reg(goti_pkg::REG_TEMP_OFF, 32'(off_x16));
        write_reg(goti_pkg::REG_IGNITE, 32'(ign));
        write_reg(goti_pkg::REG_VREF_MIN, 32'(vmin));
        write_reg(goti_pkg::REG_VREF_MAX, 32'(vmax));
        settings_applied++;
    endtask

    // Mostly well-formed tick sequences around the thresholds, the rest noise.
    task automatic queue_random_ticks(int count);
        int          lo;
        int          hi;
        int          temp;
        int          vref;
        int          sig;
        logic [31:0] step;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(99) < 22) begin
                case ($urandom_range(3))
                    0: vref = $urandom_range(65535);
                    1: vref = $urandom_range(16);
                    2: vref = int'(vref_min_cfg) + $urandom_range(4) - 2;
                    default: vref = int'(vref_max_cfg) + $urandom_range(4) - 2;
                endcase
                vref = (vref < 0) ? 0 : (vref > 65535) ? 65535 : vref;
                // Aim at the ten and ninety percent edges two times in three
                case ($urandom_range(2))
                    0: sig = $urandom_range(65535);
                    1: sig = vref / 10 + $urandom_range(4) - 2;
                    default: sig = (vref * 9) / 10 + $urandom_range(4) - 2;
                endcase
                sig = (sig < 0) ? 0 : (sig > 65535) ? 65535 : sig;
                queue_tick($urandom, 16'(vref), 16'(sig), 1'($urandom_range(1)));
            end else begin
                case ($urandom_range(19))
                    0:       step = 0;
                    1:       step = $urandom;
                    default: step = $urandom_range(int'(ignite_cfg) / 3 + 2);
                endcase
                oven_clock_ms += step;
                if (vref_min_cfg <= vref_max_cfg)
                    vref = int'(vref_min_cfg) + $urandom_range(int'(vref_max_cfg - vref_min_cfg));
                else
                    vref = $urandom_range(65535);
                lo = (temp_on_cfg < temp_off_cfg) ? int'(temp_on_cfg) : int'(temp_off_cfg);
                hi = (temp_on_cfg < temp_off_cfg) ? int'(temp_off_cfg) : int'(temp_on_cfg);
                lo = (lo - 250 < -160) ? -160 : lo - 250;
                hi = (hi + 250 > 4800) ? 4800 : hi + 250;
                if (lo > hi) lo = hi;
                if ($urandom_range(9) == 0)
                    temp = -160 + $urandom_range(4960);
                else
                    temp = lo + $urandom_range(hi - lo);
                // Invert the ratiometric map to get a signal for the wanted temperature
                sig = (vref * (780 + temp)) / 6200;
                queue_tick(oven_clock_ms, 16'(vref), 16'(sig), 1'($urandom_range(99) < 4));
            end
        end
    endtask

    initial begin
        int on_x16;
        int off_x16;
        int vmin;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed ticks at reset configuration
        @(negedge aclk);
        queue_tick(32'd0, 16'd0, 16'd0, 1'b0);              // zero reference, zero signal
        queue_tick(32'd1, 16'd0, 16'd1, 1'b0);              // zero reference, nonzero signal
        queue_tick(32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 1'b1); // every field at its top
        queue_tick(32'd100, 16'd4500, 16'd450, 1'b0);       // bottom clamp at vref_min, ignite
        queue_tick(32'd101, 16'd5500, 16'd4950, 1'b0);      // overheat while igniting
        queue_tick(32'd200, 16'd5000, 16'd2500, 1'b0);      // ignite again
        queue_tick(32'd5199, 16'd5000, 16'd2500, 1'b0);     // one ms short of the igniter time
        queue_tick(32'd5200, 16'd5000, 16'd2500, 1'b0);     // igniter time reached, heating
        queue_tick(32'd5300, 16'd5000, 16'd4000, 1'b0);     // hot, gas off
        queue_tick(32'd5400, 16'd5000, 16'd3000, 1'b0);     // above temp_off, stay idle
        queue_tick(32'd5500, 16'd5000, 16'd2900, 1'b0);     // just under temp_on
        queue_tick(32'd5600, 16'd5000, 16'd2950, 1'b0);     // inside the band, keep igniting
        queue_tick(32'd5700, 16'd5000, 16'd2500, 1'b1);     // door opens
        queue_tick(32'd5800, 16'd4499, 16'd2500, 1'b0);     // reference below limit
        queue_tick(32'd5900, 16'd5501, 16'd2500, 1'b0);     // reference above limit
        queue_tick(32'd6000, 16'd5000, 16'd499, 1'b0);      // signal under ten percent
        queue_tick(32'd6100, 16'd5000, 16'd4501, 1'b0);     // signal over ninety percent
        queue_tick(32'hFFFF_F000, 16'd5000, 16'd2500, 1'b0); // ignite just before the wrap
        queue_tick(32'h0000_0387, 16'd5000, 16'd2500, 1'b0); // wrapped, one ms short
        queue_tick(32'h0000_0388, 16'd5000, 16'd2500, 1'b0); // wrapped, heating
        queue_tick(32'h0000_0400, 16'd5000, 16'd2500, 1'b0); // keep heating
        queue_tick(32'd0, 16'hFFFF, 16'h1999, 1'b0);         // top reference, faulted
        wait_drained();

        // Reset values written back, with a long stretch of no idling and a timestamp wrap
        apply_setting(2848, 2912, 5000, 4500, 5500);
        quiet_run = 1'b1;
        oven_clock_ms = 32'hFFFE_0000;
        @(negedge aclk);
        queue_random_ticks(260);
        wait_drained();
        quiet_run = 1'b0;

        // Widest thresholds, zero igniter time, every reference accepted
        apply_setting(-160, 4800, 0, 0, 65535);
        @(negedge aclk);
        queue_random_ticks(220);
        wait_drained();

        // Inverted thresholds, longest igniter time; a write to an unused index
        apply_setting(4800, -160, 65535, 3000, 9000);
        write_reg(REG_SPARE, $urandom);
        @(negedge aclk);
        queue_random_ticks(220);
        wait_drained();

        // Only the top reference is valid
        apply_setting(1000, 1500, 1, 65535, 65535);
        @(negedge aclk);
        queue_random_ticks(180);
        wait_drained();

        // Only a zero reference is valid
        apply_setting(4800, 4800, 2, 0, 0);
        @(negedge aclk);
        queue_random_ticks(60);
        wait_drained();

        // Random settings, mostly ordered thresholds and a narrow reference window
        repeat (3) begin
            on_x16  = -160 + $urandom_range(4960);
            off_x16 = ($urandom_range(4) == 0) ? on_x16 - $urandom_range(200)
                                               : on_x16 + $urandom_range(300);
            off_x16 = (off_x16 > 4800) ? 4800 : (off_x16 < -160) ? -160 : off_x16;
            vmin    = $urandom_range(60000);
            apply_setting(on_x16, off_x16, $urandom_range(20000), vmin,
                          vmin + $urandom_range(5535));
            @(negedge aclk);
            queue_random_ticks(220);
            wait_drained();
        end

        // Let any stray result show up
        repeat (60) @(posedge aclk);

        $display("Covered %0d ticks under %0d register settings, %0d results checked.",
                 ticks_sent, settings_applied, results_checked);
        $display("Saw %0d igniting, %0d heating, %0d reference faults, %0d signal faults.",
                 igniting_seen, heating_seen, ref_faults_seen, sense_faults_seen);
        if (mismatches == 0) begin
            $display("PASS gas_oven_thermostat_igniter_top");
        end else begin
            $display("FAIL gas_oven_thermostat_igniter_top");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/goti_pkg.sv
rtl/goti_div.sv
rtl/gas_oven_thermostat_igniter_top.sv
verif/gas_oven_thermostat_igniter_top_tb.sv
